// ----- hw/rtl/swsc_pkg.sv -----
// types and constants shared by the sliding window sender control
`default_nettype none
package swsc_pkg;

   localparam int MARK_SLOTS  = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_SIZE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILE_LENGTH = 1'd1;
   localparam logic [5:0]  WINDOW_SIZE_RESET = 6'd4;
   localparam logic [31:0] FILE_LENGTH_RESET = 32'd0;

   localparam logic [1:0] CMD_SEND    = 2'd0;
   localparam logic [1:0] CMD_ACK     = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   localparam logic [2:0] KIND_PACKET  = 3'd0;
   localparam logic [2:0] KIND_ACK_OK  = 3'd1;
   localparam logic [2:0] KIND_ACK_BAD = 3'd2;
   localparam logic [2:0] KIND_ADVANCE = 3'd3;
   localparam logic [2:0] KIND_DONE    = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] ack_offset;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] offset;
      logic [10:0] length;
      logic        final_packet;
      logic [5:0]  shift;
      logic        last;
   } rsp_word_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_ACK,
      OP_TIMEOUT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] ack_offset;
   } op_word_type;

   typedef struct packed {
      logic        valid;
      op_word_type word;
   } op_head_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEND
   } back_state_type;

endpackage
`default_nettype wire

// ----- hw/rtl/swsc_front.sv -----
// front end: accepts request words, decodes commands, drops unknown ones
`default_nettype none
module swsc_front (
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire swsc_pkg::req_word_type req_word,
   input  wire logic                   q_full,
   output logic                        push,
   output swsc_pkg::op_word_type       push_word
);

   logic known;

   always_comb begin
      known = 1'b1;
      push_word.ack_offset = req_word.ack_offset;
      push_word.op = swsc_pkg::OP_SEND;
      case (req_word.cmd)
         swsc_pkg::CMD_SEND: begin
            push_word.op = swsc_pkg::OP_SEND;
         end
         swsc_pkg::CMD_ACK: begin
            push_word.op = swsc_pkg::OP_ACK;
         end
         swsc_pkg::CMD_TIMEOUT: begin
            push_word.op = swsc_pkg::OP_TIMEOUT;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   assign req_stall = q_full;
   assign push = req_valid && !q_full && known;

endmodule
`default_nettype wire

// ----- hw/rtl/swsc_queue.sv -----
// short command queue between the front end and the back end
`default_nettype none
module swsc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire swsc_pkg::op_word_type push_word,
   output logic                       full,
   input  wire logic                  pop,
   output swsc_pkg::op_head_type      head
);

   localparam int DEPTH = swsc_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   swsc_pkg::op_word_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/swsc_back.sv -----
// back end: window state, ack bitmap, descriptor sequencer and result register
`default_nettype none
module swsc_back #(
   parameter int PAYLOAD_BYTES = 1024,
   parameter int WINDOW_MAX    = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write,
   input  wire logic [swsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [swsc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  wire swsc_pkg::op_head_type                head,
   output logic                                      pop,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output swsc_pkg::rsp_word_type                    rsp_word
);

   localparam int SLOTS = swsc_pkg::MARK_SLOTS;
   localparam int WIN_CAP = (WINDOW_MAX < SLOTS) ? WINDOW_MAX : SLOTS;
   localparam logic [5:0]  WIN_CAP6 = 6'(WIN_CAP);
   localparam logic [32:0] PAY33 = 33'(PAYLOAD_BYTES);
   localparam logic [31:0] PAY32 = 32'(PAYLOAD_BYTES);

   logic [5:0]       window_size_ff;
   logic [31:0]      file_length_ff;
   logic [31:0]      base_ff, base_in;
   logic [SLOTS-1:0] marks_ff, marks_in;
   logic [31:0]      start_ff, start_in;
   logic [5:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   swsc_pkg::rsp_word_type   rsp_word_ff, rsp_word_in;
   swsc_pkg::back_state_type state_ff, state_in;

   logic [5:0]       win_eff;
   logic             ready_out;
   logic             emit;
   logic             timeout_fire;
   swsc_pkg::rsp_word_type emit_word;

   logic [31:0]      cur_start;
   logic [5:0]       cur_idx;
   logic [31:0]      rem;
   logic [31:0]      plen;
   logic [32:0]      next_start;
   logic             desc_fin;
   logic             desc_last;
   swsc_pkg::rsp_word_type desc_word;

   logic             ack_ge;
   logic [31:0]      ack_dist;
   logic [SLOTS-1:0] ack_hit;
   logic [SLOTS-1:0] win_mask;
   logic [32:0]      run_bits;
   logic [32:0]      first_zero;
   logic [5:0]       sh;
   logic [32:0]      nb_sum;
   logic [31:0]      nb;

   always_comb begin
      if (window_size_ff == 6'd0) begin
         win_eff = 6'd1;
      end else if (window_size_ff > WIN_CAP6) begin
         win_eff = WIN_CAP6;
      end else begin
         win_eff = window_size_ff;
      end
   end

   assign ready_out = !rsp_valid_ff || !rsp_stall;

   // packet descriptor for the current sequencer position
   always_comb begin
      cur_start = (state_ff == swsc_pkg::ST_SEND) ? start_ff : base_ff;
      cur_idx = (state_ff == swsc_pkg::ST_SEND) ? idx_ff : 6'd0;
      rem = file_length_ff - cur_start;
      plen = (rem < PAY32) ? rem : PAY32;
      next_start = {1'b0, cur_start} + PAY33;
      desc_fin = (next_start >= {1'b0, file_length_ff});
      desc_last = desc_fin || (6'(cur_idx + 6'd1) == win_eff);
      desc_word = '0;
      desc_word.kind = swsc_pkg::KIND_PACKET;
      desc_word.offset = cur_start;
      desc_word.length = plen[10:0];
      desc_word.final_packet = desc_fin;
      desc_word.last = desc_last;
   end

   // ack slot match against every slot boundary inside the window
   always_comb begin
      ack_ge = (head.word.ack_offset >= base_ff);
      ack_dist = head.word.ack_offset - base_ff;
      for (int k = 0; k < SLOTS; k++) begin
         win_mask[k] = (6'(k) < win_eff);
         ack_hit[k] = ack_ge && win_mask[k] && (ack_dist == 32'(k * PAYLOAD_BYTES));
      end
   end

   // leading run of acked slots, via the lowest clear bit
   always_comb begin
      run_bits = {1'b0, marks_ff & win_mask};
      first_zero = ~run_bits & (run_bits + 33'd1);
      sh = '0;
      for (int j = 0; j <= SLOTS; j++) begin
         if (first_zero[j]) begin
            sh = sh | 6'(j);
         end
      end
      nb_sum = {1'b0, base_ff} + 33'(33'(sh) * PAY33);
      nb = nb_sum[32] ? '1 : nb_sum[31:0];
   end

   always_comb begin
      state_in = state_ff;
      base_in = base_ff;
      marks_in = marks_ff;
      start_in = start_ff;
      idx_in = idx_ff;
      pop = 1'b0;
      emit = 1'b0;
      timeout_fire = 1'b0;
      emit_word = '0;
      case (state_ff)
         swsc_pkg::ST_IDLE: begin
            if (head.valid && ready_out) begin
               pop = 1'b1;
               emit = 1'b1;
               case (head.word.op)
                  swsc_pkg::OP_SEND: begin
                     if (base_ff >= file_length_ff) begin
                        emit_word.kind = swsc_pkg::KIND_DONE;
                        emit_word.offset = base_ff;
                        emit_word.last = 1'b1;
                     end else begin
                        emit_word = desc_word;
                        if (!desc_last) begin
                           state_in = swsc_pkg::ST_SEND;
                           start_in = next_start[31:0];
                           idx_in = 6'd1;
                        end
                     end
                  end
                  swsc_pkg::OP_ACK: begin
                     emit_word.kind = (|ack_hit) ? swsc_pkg::KIND_ACK_OK
                                                 : swsc_pkg::KIND_ACK_BAD;
                     emit_word.offset = head.word.ack_offset;
                     emit_word.last = 1'b1;
                     marks_in = marks_ff | ack_hit;
                  end
                  swsc_pkg::OP_TIMEOUT: begin
                     timeout_fire = 1'b1;
                     emit_word.kind = swsc_pkg::KIND_ADVANCE;
                     emit_word.offset = nb;
                     emit_word.shift = sh;
                     emit_word.last = 1'b1;
                     marks_in = '0;
                     base_in = nb;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         swsc_pkg::ST_SEND: begin
            if (ready_out) begin
               emit = 1'b1;
               emit_word = desc_word;
               if (desc_last) begin
                  state_in = swsc_pkg::ST_IDLE;
               end else begin
                  start_in = next_start[31:0];
                  idx_in = 6'(idx_ff + 6'd1);
               end
            end
         end
         default: begin
            state_in = swsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in = rsp_word_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in = emit_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swsc_pkg::ST_IDLE;
         base_ff <= '0;
         marks_ff <= '0;
         rsp_valid_ff <= 1'b0;
         window_size_ff <= swsc_pkg::WINDOW_SIZE_RESET;
         file_length_ff <= swsc_pkg::FILE_LENGTH_RESET;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         marks_ff <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               swsc_pkg::CSR_WINDOW_SIZE: begin
                  window_size_ff <= csr_data[5:0];
               end
               swsc_pkg::CSR_FILE_LENGTH: begin
                  file_length_ff <= csr_data[31:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      idx_ff <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_send_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swsc_pkg::ST_SEND) |-> (start_ff < file_length_ff) && (idx_ff < win_eff))
      else $error("descriptor sequencer past end of window or file");

   a_no_pop_in_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swsc_pkg::ST_SEND) |-> !pop)
      else $error("queue popped while descriptors pending");

   a_timeout_clears: assert property (@(posedge clock) disable iff (reset)
      timeout_fire |=> (marks_ff == '0) && rsp_valid_ff)
      else $error("timeout did not clear ack bitmap");

   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      timeout_fire |-> (sh <= win_eff) && $onehot(first_zero))
      else $error("advance exceeds window");

endmodule
`default_nettype wire

// ----- hw/rtl/sliding_window_sender_control.sv -----
// Sliding window selective repeat sender control. Request words enter through a
// decoder and a four-entry command queue; the back end executes one command at a
// time against the window base and the ack bitmap and drives a registered result
// port. An ack or a timeout yields one word. A send yields min(window, packets
// left) descriptors, or one completion word, at one word per cycle from the
// descriptor sequencer while the result port is not stalled. Unknown commands
// are accepted and dropped without a result. A command's first result is
// registered when the back end takes the command from the head of the queue.
// Configuration must be written only while idle; the block does not enforce it.
`default_nettype none
module sliding_window_sender_control #(
   parameter int PAYLOAD_BYTES = 1024,
   parameter int WINDOW_MAX    = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [swsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [swsc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire swsc_pkg::req_word_type           req_word,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output swsc_pkg::rsp_word_type                rsp_word
);

   logic                  q_full;
   logic                  push;
   logic                  pop;
   swsc_pkg::op_word_type push_word;
   swsc_pkg::op_head_type head;

   swsc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .q_full    (q_full),
      .push      (push),
      .push_word (push_word)
   );

   swsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (q_full),
      .pop       (pop),
      .head      (head)
   );

   swsc_back #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .WINDOW_MAX    (WINDOW_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
// testbench for the sliding window sender control: directed table, random rounds, checker
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned PAYLOAD      = 1024;
   localparam int unsigned WINDOW_MAX   = 32;
   localparam int unsigned WIN_CAP      = (WINDOW_MAX < swsc_pkg::MARK_SLOTS) ?
                                          WINDOW_MAX : swsc_pkg::MARK_SLOTS;
   localparam logic [1:0]  CMD_IGNORED  = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 130;
   localparam int unsigned QUIET_FROM   = 100;
   localparam int unsigned PHASE_ITEMS  = 30;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned LIMIT_CYCLES = 500000;

   typedef struct {
      bit                               is_csr;
      logic [1:0]                       cmd;
      logic [31:0]                      arg;
      logic [swsc_pkg::CSR_INDEX_W-1:0] idx;
      bit                               fixed;
      swsc_pkg::rsp_word_type           want;
   } plan_row_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_write;
   logic [swsc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [swsc_pkg::CSR_DATA_W-1:0]  csr_data;
   logic                             req_valid;
   logic                             req_stall;
   swsc_pkg::req_word_type           req_word;
   logic                             rsp_valid;
   logic                             rsp_stall;
   swsc_pkg::rsp_word_type           rsp_word;

   // sender model state
   logic [5:0]                      win_reg  = swsc_pkg::WINDOW_SIZE_RESET;
   logic [31:0]                     flen_reg = swsc_pkg::FILE_LENGTH_RESET;
   logic [31:0]                     base_q   = '0;
   logic [swsc_pkg::MARK_SLOTS-1:0] marks_q  = '0;

   swsc_pkg::rsp_word_type results_due[$];
   plan_row_type           plan[$];
   swsc_pkg::rsp_word_type want_word;

   int unsigned cycles           = 0;
   int unsigned failures         = 0;
   int unsigned words_sent       = 0;
   int unsigned rand_items       = 0;
   int unsigned results_seen     = 0;
   int unsigned descriptors_seen = 0;
   int unsigned widest_shift     = 0;
   int unsigned phases           = 0;
   bit          rand_on          = 0;
   bit          quiet            = 0;
   bit          hold_req         = 0;
   bit          hold_done        = 0;

   sliding_window_sender_control #(
      .PAYLOAD_BYTES(PAYLOAD),
      .WINDOW_MAX   (WINDOW_MAX)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d result words outstanding", cycles,
                  results_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int unsigned eff_win();
      if (win_reg < 1) return 1;
      if (win_reg > WIN_CAP) return WIN_CAP;
      return 32'(win_reg);
   endfunction

   function automatic void sender_step(input swsc_pkg::req_word_type w);
      swsc_pkg::rsp_word_type r;
      longint unsigned        base, flen, left, n, i, start, rem, d, nb;
      int unsigned            win, sh;
      win  = eff_win();
      base = 64'(base_q);
      flen = 64'(flen_reg);
      r = '0;
      r.last = 1'b1;
      case (w.cmd)
         swsc_pkg::CMD_SEND: begin
            if (base >= flen) begin
               r.kind   = swsc_pkg::KIND_DONE;
               r.offset = base_q;
               results_due.push_back(r);
            end else begin
               left = (flen - base + PAYLOAD - 1) / PAYLOAD;
               n = (left < win) ? left : win;
               for (i = 0; i < n; i++) begin
                  start = base + i * PAYLOAD;
                  rem   = flen - start;
                  r.kind         = swsc_pkg::KIND_PACKET;
                  r.offset       = 32'(start);
                  r.length       = 11'((rem < PAYLOAD) ? rem : PAYLOAD);
                  r.final_packet = (start + PAYLOAD >= flen);
                  r.last         = (i + 1 == n);
                  results_due.push_back(r);
               end
            end
         end
         swsc_pkg::CMD_ACK: begin
            r.kind   = swsc_pkg::KIND_ACK_BAD;
            r.offset = w.ack_offset;
            if (w.ack_offset >= base_q) begin
               d = longint'(w.ack_offset) - base;
               if (d % PAYLOAD == 0 && d / PAYLOAD < win) begin
                  marks_q[d / PAYLOAD] = 1'b1;
                  r.kind = swsc_pkg::KIND_ACK_OK;
               end
            end
            results_due.push_back(r);
         end
         swsc_pkg::CMD_TIMEOUT: begin
            sh = 0;
            while (sh < win && marks_q[sh]) sh++;
            nb = base + longint'(sh) * PAYLOAD;
            if (nb > 64'hFFFF_FFFF) nb = 64'hFFFF_FFFF;
            base_q  = 32'(nb);
            marks_q = '0;
            r.kind   = swsc_pkg::KIND_ADVANCE;
            r.offset = base_q;
            r.shift  = 6'(sh);
            results_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   task automatic put_word(input logic [1:0] cmd, input logic [31:0] arg);
      swsc_pkg::req_word_type w;
      int unsigned            gap;
      w.cmd        = cmd;
      w.ack_offset = arg;
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(11, 1);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_word  = w;
      do begin
         @(posedge clock);
      end while (req_stall);
      sender_step(w);
      if (cmd != CMD_IGNORED) begin
         words_sent++;
         if (rand_on) rand_items++;
      end
      quiet = rand_on && rand_items >= QUIET_FROM;
   endtask

   task automatic write_csr(input logic [swsc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx == swsc_pkg::CSR_WINDOW_SIZE) win_reg = data[5:0];
      else flen_reg = data;
   endtask

   task automatic put_noise();
      case ($urandom_range(4))
         0: put_word(swsc_pkg::CMD_ACK, $urandom());
         1: put_word(swsc_pkg::CMD_ACK, base_q + $urandom_range(eff_win() - 1) * PAYLOAD
                                        + $urandom_range(PAYLOAD - 1, 1));
         2: put_word(swsc_pkg::CMD_ACK, base_q + (eff_win() + $urandom_range(31)) * PAYLOAD);
         3: put_word(swsc_pkg::CMD_ACK,
                     (base_q == 0) ? $urandom() : $urandom_range(base_q - 1));
         default: put_word(CMD_IGNORED, $urandom());
      endcase
   endtask

   task automatic put_ack(input int unsigned slot);
      if ($urandom_range(5) == 0) put_noise();
      put_word(swsc_pkg::CMD_ACK, base_q + slot * PAYLOAD);
   endtask

   task automatic run_round();
      int unsigned win, k, s;
      win = eff_win();
      put_word(swsc_pkg::CMD_SEND, $urandom());
      k = $urandom_range(win);
      case ($urandom_range(3))
         0: for (s = 0; s < win; s++) put_ack(s);
         1: for (s = 0; s < k; s++) put_ack(s);
         2: repeat (k) put_ack($urandom_range(win - 1));
         default: begin
            for (s = 0; s < k; s++) put_ack(s);
            put_word(swsc_pkg::CMD_SEND, $urandom());
            put_ack($urandom_range(win - 1));
         end
      endcase
      put_word(swsc_pkg::CMD_TIMEOUT, $urandom());
   endtask

   task automatic add_word(input logic [1:0] cmd, input logic [31:0] arg);
      plan_row_type row;
      row = '{is_csr: 1'b0, cmd: cmd, arg: arg, idx: '0, fixed: 1'b0, want: '0};
      plan.push_back(row);
   endtask

   task automatic add_fixed(input logic [1:0] cmd, input logic [31:0] arg,
                            input logic [2:0] kind, input logic [31:0] offset,
                            input logic [5:0] shift);
      plan_row_type row;
      row = '{is_csr: 1'b0, cmd: cmd, arg: arg, idx: '0, fixed: 1'b1, want: '0};
      row.want.kind   = kind;
      row.want.offset = offset;
      row.want.shift  = shift;
      row.want.last   = 1'b1;
      plan.push_back(row);
   endtask

   task automatic add_csr(input logic [swsc_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [31:0] data);
      plan_row_type row;
      row = '{is_csr: 1'b1, cmd: swsc_pkg::CMD_SEND, arg: data, idx: idx, fixed: 1'b0,
              want: '0};
      plan.push_back(row);
   endtask

   // result side: random stall bursts plus one long hold
   initial begin
      int unsigned burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         if (burst > 0) begin
            rsp_stall = 1'b1;
            burst--;
         end else if (!quiet && $urandom_range(4) == 0) begin
            burst = $urandom_range(11, 1) - 1;
            rsp_stall = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_word.kind == swsc_pkg::KIND_PACKET) descriptors_seen++;
         if (rsp_word.kind == swsc_pkg::KIND_ADVANCE && rsp_word.shift > widest_shift)
            widest_shift = 32'(rsp_word.shift);
         if (results_due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("cycle %0d: unexpected result word kind %0d offset %h", cycles,
                        rsp_word.kind, rsp_word.offset);
         end else begin
            want_word = results_due.pop_front();
            if (rsp_word.kind !== want_word.kind || rsp_word.offset !== want_word.offset ||
                rsp_word.length !== want_word.length ||
                rsp_word.final_packet !== want_word.final_packet ||
                rsp_word.shift !== want_word.shift || rsp_word.last !== want_word.last) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display({"cycle %0d: expected kind %0d offset %h length %0d",
                            " final %0b shift %0d last %0b"},
                           cycles, want_word.kind, want_word.offset, want_word.length,
                           want_word.final_packet, want_word.shift, want_word.last);
                  $display({"          got      kind %0d offset %h length %0d",
                            " final %0b shift %0d last %0b"},
                           rsp_word.kind, rsp_word.offset, rsp_word.length,
                           rsp_word.final_packet, rsp_word.shift, rsp_word.last);
               end
            end
         end
      end
   end

   initial begin
      int unsigned directed, phase_start;
      logic [5:0]  wsel;
      logic [31:0] lsel;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_word  = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data  = '0;

      add_fixed(swsc_pkg::CMD_SEND, 32'd0, swsc_pkg::KIND_DONE, 32'd0, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd0, swsc_pkg::KIND_ACK_OK, 32'd0, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd0, swsc_pkg::KIND_ACK_OK, 32'd0, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd1, swsc_pkg::KIND_ACK_BAD, 32'd1, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd4096, swsc_pkg::KIND_ACK_BAD, 32'd4096, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'hFFFF_FFFF, swsc_pkg::KIND_ACK_BAD, 32'hFFFF_FFFF,
                6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd1024, swsc_pkg::KIND_ACK_OK, 32'd1024, 6'd0);
      add_word(CMD_IGNORED, 32'hFFFF_FFFF);
      add_fixed(swsc_pkg::CMD_TIMEOUT, 32'd0, swsc_pkg::KIND_ADVANCE, 32'd2048, 6'd2);
      add_fixed(swsc_pkg::CMD_ACK, 32'd0, swsc_pkg::KIND_ACK_BAD, 32'd0, 6'd0);
      add_fixed(swsc_pkg::CMD_SEND, 32'd0, swsc_pkg::KIND_DONE, 32'd2048, 6'd0);
      // zero window acts as one
      add_csr(swsc_pkg::CSR_WINDOW_SIZE, 32'd0);
      add_csr(swsc_pkg::CSR_FILE_LENGTH, 32'd10000);
      add_word(swsc_pkg::CMD_SEND, 32'hFFFF_FFFF);
      add_fixed(swsc_pkg::CMD_ACK, 32'd3072, swsc_pkg::KIND_ACK_BAD, 32'd3072, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd2048, swsc_pkg::KIND_ACK_OK, 32'd2048, 6'd0);
      // oversized window clamps to the slot count; send keeps pending marks
      add_csr(swsc_pkg::CSR_WINDOW_SIZE, 32'd63);
      add_word(swsc_pkg::CMD_SEND, 32'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd33792, swsc_pkg::KIND_ACK_OK, 32'd33792, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd34816, swsc_pkg::KIND_ACK_BAD, 32'd34816, 6'd0);
      add_fixed(swsc_pkg::CMD_TIMEOUT, 32'd0, swsc_pkg::KIND_ADVANCE, 32'd3072, 6'd1);
      add_csr(swsc_pkg::CSR_FILE_LENGTH, 32'hFFFF_FFFF);
      add_csr(swsc_pkg::CSR_WINDOW_SIZE, 32'd3);
      add_word(swsc_pkg::CMD_SEND, 32'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd3072, swsc_pkg::KIND_ACK_OK, 32'd3072, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd4096, swsc_pkg::KIND_ACK_OK, 32'd4096, 6'd0);
      add_fixed(swsc_pkg::CMD_ACK, 32'd5120, swsc_pkg::KIND_ACK_OK, 32'd5120, 6'd0);
      // shrink below a marked slot, then grow back to see it cleared
      add_csr(swsc_pkg::CSR_WINDOW_SIZE, 32'd2);
      add_fixed(swsc_pkg::CMD_TIMEOUT, 32'd0, swsc_pkg::KIND_ADVANCE, 32'd5120, 6'd2);
      add_csr(swsc_pkg::CSR_WINDOW_SIZE, 32'd3);
      add_fixed(swsc_pkg::CMD_TIMEOUT, 32'd0, swsc_pkg::KIND_ADVANCE, 32'd5120, 6'd0);
      add_csr(swsc_pkg::CSR_FILE_LENGTH, 32'd5121);
      add_word(swsc_pkg::CMD_SEND, 32'd0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[r]) begin
         if (plan[r].is_csr) begin
            write_csr(plan[r].idx, plan[r].arg);
         end else begin
            put_word(plan[r].cmd, plan[r].arg);
            if (plan[r].fixed) results_due[results_due.size() - 1] = plan[r].want;
         end
      end
      directed = words_sent;

      rand_on = 1'b1;
      while (rand_items < RANDOM_ITEMS) begin
         if (phases == 0) begin
            wsel = 6'($urandom_range(32, 8));
            lsel = '1;
         end else begin
            case ($urandom_range(3))
               0: wsel = 6'd1;
               1: wsel = 6'd32;
               2: wsel = 6'd63;
               default: wsel = 6'($urandom_range(31, 2));
            endcase
            case ($urandom_range(3))
               0: lsel = base_q + $urandom_range(40 * PAYLOAD, 1);
               1: lsel = '1;
               2: lsel = $urandom();
               default: lsel = base_q + $urandom_range(3 * PAYLOAD);
            endcase
         end
         write_csr(swsc_pkg::CSR_WINDOW_SIZE, {26'd0, wsel});
         write_csr(swsc_pkg::CSR_FILE_LENGTH, lsel);
         if (phases == 0) hold_req = 1'b1;
         phase_start = rand_items;
         while (rand_items - phase_start < PHASE_ITEMS && rand_items < RANDOM_ITEMS)
            run_round();
         phases++;
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      failures += results_due.size();

      $display("covered %0d request words (%0d from the directed table) over %0d random phases",
               words_sent, directed, phases);
      $display("checked %0d result words, %0d descriptors, widest advance %0d slots",
               results_seen, descriptors_seen, widest_shift);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
